// ===== rtl/core/call_return_time_profiler_defines.svh =====
// Assertion macros for the call/return time profiler.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef CALL_RETURN_TIME_PROFILER_DEFINES_SVH
`define CALL_RETURN_TIME_PROFILER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define CRTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define CRTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/crtp_pkg.sv =====
// Shared types and constants of the call/return time profiler.
// No dependencies.
package crtp_pkg;

   localparam int ENTRY_DEPTH_DEF  = 64;
   localparam int FRAME_DEPTH_DEF  = 64;
   localparam int SAMPLE_DEPTH_DEF = 256;

   typedef enum logic [2:0] {
      REQ_CALL     = 3'd0,
      REQ_RETURN   = 3'd1,
      REQ_SAMPLE   = 3'd2,
      REQ_RD_ENTRY = 3'd3,
      REQ_RD_SMP   = 3'd4,
      REQ_CLEAR    = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_OK           = 3'd0,
      STAT_FULL         = 3'd1,
      STAT_NO_FRAME     = 3'd2,
      STAT_SAMPLING_OFF = 3'd3,
      STAT_RANGE        = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ENTRY,
      KIND_SAMPLE
   } kind_type;

   typedef enum logic [4:0] {
      FSM_IDLE,
      FSM_DISP,
      FSM_E_RD,
      FSM_E_CMP,
      FSM_E_UPD,
      FSM_F_RD,
      FSM_F_CMP,
      FSM_T_EL,
      FSM_T_SELF,
      FSM_T_ACC,
      FSM_P_RD,
      FSM_P_WR,
      FSM_S_RD,
      FSM_S_CMP,
      FSM_S_WR,
      FSM_RE_RD,
      FSM_RE_OUT,
      FSM_RS_RD,
      FSM_RS_OUT,
      FSM_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] func;
      logic [31:0] calls;
      logic [31:0] returns;
      logic [63:0] total;
      logic [63:0] own;
   } entry_type;

endpackage

// ===== rtl/core/call_return_time_profiler.sv =====
// Call/return time profiler: function table, frame stack and sample histogram.
// Depends on crtp_pkg and call_return_time_profiler_defines.svh.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   type, function id, line, timestamp, index
//  rsp      out        rsp_valid/rsp_stall   status, slots, counts, times, location
//  csr      in         csr_wr_en             sampling enable bit
//
// One item at a time. A call scans the used function slots through the registered
// entry memory; a return also searches the frame stack from the top, then works
// out elapsed and own time. Sample ticks scan the used histogram slots; reads
// fetch one slot, clear resets the counts. Reset needs no clearing pass. The result
// sits in an output register, so the next request is taken while it waits.
`include "call_return_time_profiler_defines.svh"

module call_return_time_profiler #(
   parameter int ENTRY_DEPTH  = crtp_pkg::ENTRY_DEPTH_DEF,
   parameter int FRAME_DEPTH  = crtp_pkg::FRAME_DEPTH_DEF,
   parameter int SAMPLE_DEPTH = crtp_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_function_id,
   input  logic [23:0] req_line_number,
   input  logic [63:0] req_timestamp_ns,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_entry_slot,
   output logic [7:0]  rsp_sample_slot,
   output logic [31:0] rsp_calls_seen,
   output logic [31:0] rsp_returns_seen,
   output logic [63:0] rsp_total_time,
   output logic [63:0] rsp_own_time,
   output logic [31:0] rsp_hits_at_location,
   output logic [63:0] rsp_all_samples,
   output logic [31:0] rsp_slot_function,
   output logic [23:0] rsp_slot_line
);

   localparam int EW = $clog2(ENTRY_DEPTH);
   localparam int EC = $clog2(ENTRY_DEPTH + 1);
   localparam int FW = $clog2(FRAME_DEPTH);
   localparam int FC = $clog2(FRAME_DEPTH + 1);
   localparam int SW = $clog2(SAMPLE_DEPTH);
   localparam int SC = $clog2(SAMPLE_DEPTH + 1);

   // control state
   crtp_pkg::state_type st_ff, st_in;
   logic [EC-1:0] entries_used_ff, entries_used_in;
   logic [FC-1:0] depth_ff, depth_in;
   logic [SC-1:0] samples_used_ff, samples_used_in;
   logic [63:0]   sample_total_ff, sample_total_in;
   logic          smp_en_ff, smp_en_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // captured request and working registers
   crtp_pkg::req_code_type req_ff, req_in;
   logic [31:0] fn_ff, fn_in;
   logic [23:0] line_ff, line_in;
   logic [63:0] now_ff, now_in;
   logic [7:0]  ridx_ff, ridx_in;
   logic [EC-1:0] e_idx_ff, e_idx_in;
   logic [FC-1:0] f_idx_ff, f_idx_in;
   logic [SC-1:0] s_idx_ff, s_idx_in;
   crtp_pkg::entry_type ent_ff, ent_in;
   logic [EW-1:0] eslot_ff, eslot_in;
   logic [63:0] fr_start_ff, fr_start_in;
   logic [63:0] fr_child_ff, fr_child_in;
   logic [63:0] el_ff, el_in;
   logic [63:0] own_ff, own_in;
   logic [31:0] sfunc_ff, sfunc_in;
   logic [23:0] sline_ff, sline_in;
   logic [31:0] shits_ff, shits_in;
   logic [SW-1:0] sslot_ff, sslot_in;
   crtp_pkg::status_type status_ff, status_in;
   crtp_pkg::kind_type   kind_ff, kind_in;

   // result registers
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_eslot_ff, rsp_eslot_in;
   logic [7:0]  rsp_sslot_ff, rsp_sslot_in;
   logic [31:0] rsp_calls_ff, rsp_calls_in;
   logic [31:0] rsp_returns_ff, rsp_returns_in;
   logic [63:0] rsp_total_ff, rsp_total_in;
   logic [63:0] rsp_own_ff, rsp_own_in;
   logic [31:0] rsp_hits_ff, rsp_hits_in;
   logic [63:0] rsp_all_ff, rsp_all_in;
   logic [31:0] rsp_func_ff, rsp_func_in;
   logic [23:0] rsp_line_ff, rsp_line_in;

   // memories
   crtp_pkg::entry_type ent_mem [ENTRY_DEPTH];
   crtp_pkg::entry_type ent_rd_ff;
   logic          ent_we;
   logic [EW-1:0] ent_wa, ent_ra;

   logic [EW-1:0] frm_entry_mem [FRAME_DEPTH];
   logic [63:0]   frm_start_mem [FRAME_DEPTH];
   logic [63:0]   frm_child_mem [FRAME_DEPTH];
   logic [EW-1:0] frm_entry_rd_ff;
   logic [63:0]   frm_start_rd_ff, frm_child_rd_ff;
   logic          frm_we;
   logic [FW-1:0] frm_wa, frm_ra;
   logic [EW-1:0] frm_wentry;
   logic [63:0]   frm_wstart, frm_wchild;

   logic [31:0]   smp_func_mem [SAMPLE_DEPTH];
   logic [23:0]   smp_line_mem [SAMPLE_DEPTH];
   logic [31:0]   smp_hits_mem [SAMPLE_DEPTH];
   logic [31:0]   smp_func_rd_ff, smp_hits_rd_ff;
   logic [23:0]   smp_line_rd_ff;
   logic          smp_we;
   logic [SW-1:0] smp_wa, smp_ra;

   // helpers
   logic req_xfer, e_hit, e_last, e_full, f_hit, stk_full, s_hit, s_last, s_full;
   logic re_ok, rs_ok, out_free;
   logic [EC+7:0] ridx_xe, used_xe;
   logic [SC+7:0] ridx_xs, used_xs;
   logic [EW+5:0] eslot_x;
   logic [SW+7:0] sslot_x;
   logic [FC-1:0] f_prev;

   assign req_stall = (st_ff != crtp_pkg::FSM_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign e_hit    = (ent_rd_ff.func == fn_ff);
   assign e_last   = ((e_idx_ff + EC'(1)) == entries_used_ff);
   assign e_full   = (entries_used_ff == EC'(ENTRY_DEPTH));
   assign f_hit    = (frm_entry_rd_ff == eslot_ff);
   assign stk_full = (depth_ff == FC'(FRAME_DEPTH));
   assign f_prev   = f_idx_ff - FC'(1);
   assign s_hit    = (smp_func_rd_ff == fn_ff) && (smp_line_rd_ff == line_ff);
   assign s_last   = ((s_idx_ff + SC'(1)) == samples_used_ff);
   assign s_full   = (samples_used_ff == SC'(SAMPLE_DEPTH));

   assign ridx_xe = {{EC{1'b0}}, ridx_ff};
   assign used_xe = {8'd0, entries_used_ff};
   assign ridx_xs = {{SC{1'b0}}, ridx_ff};
   assign used_xs = {8'd0, samples_used_ff};
   assign re_ok   = (ridx_xe < used_xe);
   assign rs_ok   = (ridx_xs < used_xs);
   assign eslot_x = {6'd0, eslot_ff};
   assign sslot_x = {8'd0, sslot_ff};

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         crtp_pkg::FSM_IDLE: begin
            if (req_xfer) st_in = crtp_pkg::FSM_DISP;
         end
         crtp_pkg::FSM_DISP: begin
            case (req_ff)
               crtp_pkg::REQ_CALL, crtp_pkg::REQ_RETURN: begin
                  st_in = (entries_used_ff == '0) ? crtp_pkg::FSM_E_UPD : crtp_pkg::FSM_E_RD;
               end
               crtp_pkg::REQ_SAMPLE: begin
                  if (!smp_en_ff) st_in = crtp_pkg::FSM_RESP;
                  else if (samples_used_ff == '0) st_in = crtp_pkg::FSM_S_WR;
                  else st_in = crtp_pkg::FSM_S_RD;
               end
               crtp_pkg::REQ_RD_ENTRY: begin
                  st_in = re_ok ? crtp_pkg::FSM_RE_RD : crtp_pkg::FSM_RESP;
               end
               crtp_pkg::REQ_RD_SMP: begin
                  st_in = rs_ok ? crtp_pkg::FSM_RS_RD : crtp_pkg::FSM_RESP;
               end
               default: st_in = crtp_pkg::FSM_RESP;
            endcase
         end
         crtp_pkg::FSM_E_RD: st_in = crtp_pkg::FSM_E_CMP;
         crtp_pkg::FSM_E_CMP: begin
            if (e_hit) st_in = crtp_pkg::FSM_E_UPD;
            else if (!e_last) st_in = crtp_pkg::FSM_E_RD;
            else if (e_full) st_in = crtp_pkg::FSM_RESP;
            else st_in = crtp_pkg::FSM_E_UPD;
         end
         crtp_pkg::FSM_E_UPD: begin
            if (req_ff == crtp_pkg::REQ_RETURN && depth_ff != '0) st_in = crtp_pkg::FSM_F_RD;
            else st_in = crtp_pkg::FSM_RESP;
         end
         crtp_pkg::FSM_F_RD: st_in = crtp_pkg::FSM_F_CMP;
         crtp_pkg::FSM_F_CMP: begin
            if (f_hit) st_in = crtp_pkg::FSM_T_EL;
            else if (f_idx_ff == '0) st_in = crtp_pkg::FSM_RESP;
            else st_in = crtp_pkg::FSM_F_RD;
         end
         crtp_pkg::FSM_T_EL:   st_in = crtp_pkg::FSM_T_SELF;
         crtp_pkg::FSM_T_SELF: st_in = crtp_pkg::FSM_T_ACC;
         crtp_pkg::FSM_T_ACC: begin
            st_in = (f_idx_ff == '0) ? crtp_pkg::FSM_RESP : crtp_pkg::FSM_P_RD;
         end
         crtp_pkg::FSM_P_RD: st_in = crtp_pkg::FSM_P_WR;
         crtp_pkg::FSM_P_WR: st_in = crtp_pkg::FSM_RESP;
         crtp_pkg::FSM_S_RD: st_in = crtp_pkg::FSM_S_CMP;
         crtp_pkg::FSM_S_CMP: begin
            if (s_hit) st_in = crtp_pkg::FSM_S_WR;
            else if (!s_last) st_in = crtp_pkg::FSM_S_RD;
            else if (s_full) st_in = crtp_pkg::FSM_RESP;
            else st_in = crtp_pkg::FSM_S_WR;
         end
         crtp_pkg::FSM_S_WR:   st_in = crtp_pkg::FSM_RESP;
         crtp_pkg::FSM_RE_RD:  st_in = crtp_pkg::FSM_RE_OUT;
         crtp_pkg::FSM_RE_OUT: st_in = crtp_pkg::FSM_RESP;
         crtp_pkg::FSM_RS_RD:  st_in = crtp_pkg::FSM_RS_OUT;
         crtp_pkg::FSM_RS_OUT: st_in = crtp_pkg::FSM_RESP;
         crtp_pkg::FSM_RESP: begin
            if (out_free) st_in = crtp_pkg::FSM_IDLE;
         end
         default: st_in = crtp_pkg::FSM_IDLE;
      endcase
   end

   // datapath, memory controls and result loading
   always_comb begin
      entries_used_in = entries_used_ff;
      depth_in        = depth_ff;
      samples_used_in = samples_used_ff;
      sample_total_in = sample_total_ff;
      smp_en_in       = csr_wr_en ? csr_wr_data : smp_en_ff;
      req_in    = req_ff;
      fn_in     = fn_ff;
      line_in   = line_ff;
      now_in    = now_ff;
      ridx_in   = ridx_ff;
      e_idx_in  = e_idx_ff;
      f_idx_in  = f_idx_ff;
      s_idx_in  = s_idx_ff;
      ent_in    = ent_ff;
      eslot_in  = eslot_ff;
      fr_start_in = fr_start_ff;
      fr_child_in = fr_child_ff;
      el_in     = el_ff;
      own_in    = own_ff;
      sfunc_in  = sfunc_ff;
      sline_in  = sline_ff;
      shits_in  = shits_ff;
      sslot_in  = sslot_ff;
      status_in = status_ff;
      kind_in   = kind_ff;
      ent_we = 1'b0;
      ent_wa = eslot_ff;
      ent_ra = e_idx_ff[EW-1:0];
      frm_we = 1'b0;
      frm_wa = depth_ff[FW-1:0];
      frm_ra = f_idx_ff[FW-1:0];
      frm_wentry = eslot_ff;
      frm_wstart = now_ff;
      frm_wchild = 64'd0;
      smp_we = 1'b0;
      smp_wa = sslot_ff;
      smp_ra = s_idx_ff[SW-1:0];
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_eslot_in   = rsp_eslot_ff;
      rsp_sslot_in   = rsp_sslot_ff;
      rsp_calls_in   = rsp_calls_ff;
      rsp_returns_in = rsp_returns_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_own_in     = rsp_own_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_all_in     = rsp_all_ff;
      rsp_func_in    = rsp_func_ff;
      rsp_line_in    = rsp_line_ff;

      // drop the result once the far side takes it
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (st_ff)
         crtp_pkg::FSM_IDLE: begin
            if (req_xfer) begin
               req_in  = crtp_pkg::req_code_type'(req_type);
               fn_in   = req_function_id;
               line_in = req_line_number;
               now_in  = req_timestamp_ns;
               ridx_in = req_read_index;
            end
         end
         crtp_pkg::FSM_DISP: begin
            status_in = crtp_pkg::STAT_OK;
            kind_in   = crtp_pkg::KIND_NONE;
            case (req_ff)
               crtp_pkg::REQ_CALL, crtp_pkg::REQ_RETURN: begin
                  e_idx_in = '0;
                  if (entries_used_ff == '0) begin
                     ent_in          = '0;
                     ent_in.func     = fn_ff;
                     eslot_in        = '0;
                     entries_used_in = EC'(1);
                  end
               end
               crtp_pkg::REQ_SAMPLE: begin
                  s_idx_in = '0;
                  if (!smp_en_ff) begin
                     status_in = crtp_pkg::STAT_SAMPLING_OFF;
                  end else if (samples_used_ff == '0) begin
                     sfunc_in        = fn_ff;
                     sline_in        = line_ff;
                     shits_in        = 32'd1;
                     sslot_in        = '0;
                     samples_used_in = SC'(1);
                  end
               end
               crtp_pkg::REQ_RD_ENTRY: begin
                  if (!re_ok) status_in = crtp_pkg::STAT_RANGE;
               end
               crtp_pkg::REQ_RD_SMP: begin
                  if (!rs_ok) status_in = crtp_pkg::STAT_RANGE;
               end
               crtp_pkg::REQ_CLEAR: begin
                  entries_used_in = '0;
                  depth_in        = '0;
                  samples_used_in = '0;
                  sample_total_in = 64'd0;
               end
               default: ;
            endcase
         end
         crtp_pkg::FSM_E_CMP: begin
            if (e_hit) begin
               ent_in   = ent_rd_ff;
               eslot_in = e_idx_ff[EW-1:0];
            end else if (!e_last) begin
               e_idx_in = e_idx_ff + EC'(1);
            end else if (e_full) begin
               status_in = crtp_pkg::STAT_FULL;
            end else begin
               ent_in          = '0;
               ent_in.func     = fn_ff;
               eslot_in        = entries_used_ff[EW-1:0];
               entries_used_in = entries_used_ff + EC'(1);
            end
         end
         crtp_pkg::FSM_E_UPD: begin
            kind_in = crtp_pkg::KIND_ENTRY;
            if (req_ff == crtp_pkg::REQ_CALL) begin
               ent_in.calls = ent_ff.calls + 32'd1;
               ent_we = 1'b1;
               if (stk_full) begin
                  status_in = crtp_pkg::STAT_FULL;
               end else begin
                  // push a frame for this call
                  frm_we   = 1'b1;
                  depth_in = depth_ff + FC'(1);
               end
            end else begin
               ent_in.returns = ent_ff.returns + 32'd1;
               if (depth_ff == '0) begin
                  status_in = crtp_pkg::STAT_NO_FRAME;
                  ent_we    = 1'b1;
               end else begin
                  f_idx_in = depth_ff - FC'(1);
               end
            end
         end
         crtp_pkg::FSM_F_CMP: begin
            if (f_hit) begin
               fr_start_in = frm_start_rd_ff;
               fr_child_in = frm_child_rd_ff;
            end else if (f_idx_ff == '0) begin
               status_in = crtp_pkg::STAT_NO_FRAME;
               ent_we    = 1'b1;
            end else begin
               f_idx_in = f_prev;
            end
         end
         crtp_pkg::FSM_T_EL: begin
            el_in = (now_ff >= fr_start_ff) ? now_ff - fr_start_ff : 64'd0;
         end
         crtp_pkg::FSM_T_SELF: begin
            own_in = (el_ff >= fr_child_ff) ? el_ff - fr_child_ff : 64'd0;
         end
         crtp_pkg::FSM_T_ACC: begin
            // pop down to the found frame and accumulate
            ent_in.total = ent_ff.total + el_ff;
            ent_in.own   = ent_ff.own + own_ff;
            ent_we       = 1'b1;
            depth_in     = f_idx_ff;
         end
         crtp_pkg::FSM_P_RD: begin
            frm_ra = f_prev[FW-1:0];
         end
         crtp_pkg::FSM_P_WR: begin
            // charge the elapsed time to the caller frame
            frm_we     = 1'b1;
            frm_wa     = f_prev[FW-1:0];
            frm_wentry = frm_entry_rd_ff;
            frm_wstart = frm_start_rd_ff;
            frm_wchild = frm_child_rd_ff + el_ff;
         end
         crtp_pkg::FSM_S_CMP: begin
            if (s_hit) begin
               sfunc_in = smp_func_rd_ff;
               sline_in = smp_line_rd_ff;
               shits_in = smp_hits_rd_ff + 32'd1;
               sslot_in = s_idx_ff[SW-1:0];
            end else if (!s_last) begin
               s_idx_in = s_idx_ff + SC'(1);
            end else if (s_full) begin
               status_in = crtp_pkg::STAT_FULL;
            end else begin
               sfunc_in        = fn_ff;
               sline_in        = line_ff;
               shits_in        = 32'd1;
               sslot_in        = samples_used_ff[SW-1:0];
               samples_used_in = samples_used_ff + SC'(1);
            end
         end
         crtp_pkg::FSM_S_WR: begin
            smp_we          = 1'b1;
            sample_total_in = sample_total_ff + 64'd1;
            kind_in         = crtp_pkg::KIND_SAMPLE;
         end
         crtp_pkg::FSM_RE_RD: begin
            ent_ra = ridx_xe[EW-1:0];
         end
         crtp_pkg::FSM_RE_OUT: begin
            ent_in   = ent_rd_ff;
            eslot_in = ridx_xe[EW-1:0];
            kind_in  = crtp_pkg::KIND_ENTRY;
         end
         crtp_pkg::FSM_RS_RD: begin
            smp_ra = ridx_xs[SW-1:0];
         end
         crtp_pkg::FSM_RS_OUT: begin
            sfunc_in = smp_func_rd_ff;
            sline_in = smp_line_rd_ff;
            shits_in = smp_hits_rd_ff;
            sslot_in = ridx_xs[SW-1:0];
            kind_in  = crtp_pkg::KIND_SAMPLE;
         end
         crtp_pkg::FSM_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_eslot_in   = 6'd0;
               rsp_sslot_in   = 8'd0;
               rsp_calls_in   = 32'd0;
               rsp_returns_in = 32'd0;
               rsp_total_in   = 64'd0;
               rsp_own_in     = 64'd0;
               rsp_hits_in    = 32'd0;
               rsp_all_in     = 64'd0;
               rsp_func_in    = 32'd0;
               rsp_line_in    = 24'd0;
               case (kind_ff)
                  crtp_pkg::KIND_ENTRY: begin
                     rsp_eslot_in   = eslot_x[5:0];
                     rsp_calls_in   = ent_ff.calls;
                     rsp_returns_in = ent_ff.returns;
                     rsp_total_in   = ent_ff.total;
                     rsp_own_in     = ent_ff.own;
                     rsp_func_in    = ent_ff.func;
                  end
                  crtp_pkg::KIND_SAMPLE: begin
                     rsp_sslot_in = sslot_x[7:0];
                     rsp_hits_in  = shits_ff;
                     rsp_all_in   = sample_total_ff;
                     rsp_func_in  = sfunc_ff;
                     rsp_line_in  = sline_ff;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= crtp_pkg::FSM_IDLE;
         entries_used_ff <= '0;
         depth_ff        <= '0;
         samples_used_ff <= '0;
         sample_total_ff <= 64'd0;
         smp_en_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         entries_used_ff <= entries_used_in;
         depth_ff        <= depth_in;
         samples_used_ff <= samples_used_in;
         sample_total_ff <= sample_total_in;
         smp_en_ff       <= smp_en_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      fn_ff       <= fn_in;
      line_ff     <= line_in;
      now_ff      <= now_in;
      ridx_ff     <= ridx_in;
      e_idx_ff    <= e_idx_in;
      f_idx_ff    <= f_idx_in;
      s_idx_ff    <= s_idx_in;
      ent_ff      <= ent_in;
      eslot_ff    <= eslot_in;
      fr_start_ff <= fr_start_in;
      fr_child_ff <= fr_child_in;
      el_ff       <= el_in;
      own_ff      <= own_in;
      sfunc_ff    <= sfunc_in;
      sline_ff    <= sline_in;
      shits_ff    <= shits_in;
      sslot_ff    <= sslot_in;
      status_ff   <= status_in;
      kind_ff     <= kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_eslot_ff   <= rsp_eslot_in;
      rsp_sslot_ff   <= rsp_sslot_in;
      rsp_calls_ff   <= rsp_calls_in;
      rsp_returns_ff <= rsp_returns_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_own_ff     <= rsp_own_in;
      rsp_hits_ff    <= rsp_hits_in;
      rsp_all_ff     <= rsp_all_in;
      rsp_func_ff    <= rsp_func_in;
      rsp_line_ff    <= rsp_line_in;
   end

   // function table memory
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_in;
      ent_rd_ff <= ent_mem[ent_ra];
   end

   // frame stack memory
   always_ff @(posedge clock) begin
      if (frm_we) begin
         frm_entry_mem[frm_wa] <= frm_wentry;
         frm_start_mem[frm_wa] <= frm_wstart;
         frm_child_mem[frm_wa] <= frm_wchild;
      end
      frm_entry_rd_ff <= frm_entry_mem[frm_ra];
      frm_start_rd_ff <= frm_start_mem[frm_ra];
      frm_child_rd_ff <= frm_child_mem[frm_ra];
   end

   // sample histogram memory
   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_func_mem[smp_wa] <= sfunc_ff;
         smp_line_mem[smp_wa] <= sline_ff;
         smp_hits_mem[smp_wa] <= shits_ff;
      end
      smp_func_rd_ff <= smp_func_mem[smp_ra];
      smp_line_rd_ff <= smp_line_mem[smp_ra];
      smp_hits_rd_ff <= smp_hits_mem[smp_ra];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_slot       = rsp_eslot_ff;
   assign rsp_sample_slot      = rsp_sslot_ff;
   assign rsp_calls_seen       = rsp_calls_ff;
   assign rsp_returns_seen     = rsp_returns_ff;
   assign rsp_total_time       = rsp_total_ff;
   assign rsp_own_time         = rsp_own_ff;
   assign rsp_hits_at_location = rsp_hits_ff;
   assign rsp_all_samples      = rsp_all_ff;
   assign rsp_slot_function    = rsp_func_ff;
   assign rsp_slot_line        = rsp_line_ff;

   `CRTP_ASSERT_NOW(a_entries_bound, 1'b1, entries_used_ff <= EC'(ENTRY_DEPTH), "entry count overflow")
   `CRTP_ASSERT_NOW(a_stack_bound, 1'b1, depth_ff <= FC'(FRAME_DEPTH), "stack depth overflow")
   `CRTP_ASSERT_NOW(a_samples_bound, 1'b1, samples_used_ff <= SC'(SAMPLE_DEPTH), "sample count overflow")
   `CRTP_ASSERT_NEXT(a_busy_after_xfer, req_xfer, st_ff == crtp_pkg::FSM_DISP, "request not dispatched")

endmodule

// ===== tb/call_return_time_profiler_tb.sv =====
// Self-checking testbench of the call/return time profiler: directed and random
// event streams against a built-in predictor of tables, frame stack and histogram.
// Depends on crtp_pkg and the call_return_time_profiler RTL.
module call_return_time_profiler_tb;

   localparam int NUM_ENTRIES = crtp_pkg::ENTRY_DEPTH_DEF;
   localparam int NUM_FRAMES  = crtp_pkg::FRAME_DEPTH_DEF;
   localparam int NUM_SAMPLES = crtp_pkg::SAMPLE_DEPTH_DEF;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] func;
      logic [23:0] line;
      logic [63:0] stamp;
      logic [7:0]  index;
   } event_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [5:0]  entry_slot;
      logic [7:0]  sample_slot;
      logic [31:0] calls;
      logic [31:0] returns;
      logic [63:0] total;
      logic [63:0] own;
      logic [31:0] hits;
      logic [63:0] all_samples;
      logic [31:0] slot_func;
      logic [23:0] slot_line;
   } profile_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0]  req_type = '0;
   logic [31:0] req_function_id = '0;
   logic [23:0] req_line_number = '0;
   logic [63:0] req_timestamp_ns = '0;
   logic [7:0]  req_read_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_entry_slot;
   logic [7:0]  rsp_sample_slot;
   logic [31:0] rsp_calls_seen, rsp_returns_seen, rsp_hits_at_location, rsp_slot_function;
   logic [63:0] rsp_total_time, rsp_own_time, rsp_all_samples;
   logic [23:0] rsp_slot_line;

   call_return_time_profiler i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        sampling_on;
   logic [31:0] fn_id [NUM_ENTRIES];
   logic [31:0] fn_calls [NUM_ENTRIES];
   logic [31:0] fn_returns [NUM_ENTRIES];
   logic [63:0] fn_total [NUM_ENTRIES];
   logic [63:0] fn_own [NUM_ENTRIES];
   int          fn_count;
   int          frm_fn [NUM_FRAMES];
   logic [63:0] frm_start [NUM_FRAMES];
   logic [63:0] frm_child [NUM_FRAMES];
   int          frm_depth;
   logic [31:0] loc_func [NUM_SAMPLES];
   logic [23:0] loc_line [NUM_SAMPLES];
   logic [31:0] loc_hits [NUM_SAMPLES];
   int          loc_count;
   logic [63:0] samples_total;

   event_item_type     pending_events[$];
   profile_result_type expected_results[$];
   bit  failed = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_cycles = 0;
   longint cycle_count = 0;

   function automatic int find_function(logic [31:0] f);
      for (int i = 0; i < fn_count; i++)
         if (fn_id[i] == f) return i;
      if (fn_count >= NUM_ENTRIES) return -1;
      fn_id[fn_count] = f;
      fn_calls[fn_count] = '0;
      fn_returns[fn_count] = '0;
      fn_total[fn_count] = '0;
      fn_own[fn_count] = '0;
      fn_count++;
      return fn_count - 1;
   endfunction

   function automatic int find_location(logic [31:0] f, logic [23:0] l);
      for (int i = 0; i < loc_count; i++)
         if (loc_func[i] == f && loc_line[i] == l) return i;
      if (loc_count >= NUM_SAMPLES) return -1;
      loc_func[loc_count] = f;
      loc_line[loc_count] = l;
      loc_hits[loc_count] = '0;
      loc_count++;
      return loc_count - 1;
   endfunction

   function automatic void fill_entry(ref profile_result_type r, input int e);
      r.entry_slot = e[5:0];
      r.calls = fn_calls[e];
      r.returns = fn_returns[e];
      r.total = fn_total[e];
      r.own = fn_own[e];
      r.slot_func = fn_id[e];
   endfunction

   function automatic void fill_location(ref profile_result_type r, input int s);
      r.sample_slot = s[7:0];
      r.hits = loc_hits[s];
      r.all_samples = samples_total;
      r.slot_func = loc_func[s];
      r.slot_line = loc_line[s];
   endfunction

   // work out the result of one event and advance the predicted state
   function automatic profile_result_type profile_event(event_item_type ev);
      profile_result_type r = '{default: '0};
      int e, f, s;
      logic [63:0] elapsed, self_t;
      bit found;
      case (ev.kind)
         crtp_pkg::REQ_CALL: begin
            e = find_function(ev.func);
            if (e < 0) begin
               r.status = crtp_pkg::STAT_FULL;
            end else begin
               fn_calls[e]++;
               if (frm_depth >= NUM_FRAMES) r.status = crtp_pkg::STAT_FULL;
               else begin
                  frm_fn[frm_depth] = e;
                  frm_start[frm_depth] = ev.stamp;
                  frm_child[frm_depth] = '0;
                  frm_depth++;
               end
               fill_entry(r, e);
            end
         end
         crtp_pkg::REQ_RETURN: begin
            e = find_function(ev.func);
            if (e < 0) begin
               r.status = crtp_pkg::STAT_FULL;
            end else begin
               fn_returns[e]++;
               found = 0;
               f = frm_depth;
               while (f > 0 && !found) begin
                  f--;
                  if (frm_fn[f] == e) found = 1;
               end
               if (!found) r.status = crtp_pkg::STAT_NO_FRAME;
               else begin
                  elapsed = (ev.stamp >= frm_start[f]) ? ev.stamp - frm_start[f] : '0;
                  self_t = (elapsed >= frm_child[f]) ? elapsed - frm_child[f] : '0;
                  frm_depth = f;
                  fn_total[e] += elapsed;
                  fn_own[e] += self_t;
                  if (frm_depth > 0) frm_child[frm_depth-1] += elapsed;
               end
               fill_entry(r, e);
            end
         end
         crtp_pkg::REQ_SAMPLE: begin
            if (!sampling_on) r.status = crtp_pkg::STAT_SAMPLING_OFF;
            else begin
               s = find_location(ev.func, ev.line);
               if (s < 0) r.status = crtp_pkg::STAT_FULL;
               else begin
                  loc_hits[s]++;
                  samples_total++;
                  fill_location(r, s);
               end
            end
         end
         crtp_pkg::REQ_RD_ENTRY: begin
            if (int'(ev.index) >= fn_count) r.status = crtp_pkg::STAT_RANGE;
            else fill_entry(r, int'(ev.index));
         end
         crtp_pkg::REQ_RD_SMP: begin
            if (int'(ev.index) >= loc_count) r.status = crtp_pkg::STAT_RANGE;
            else fill_location(r, int'(ev.index));
         end
         crtp_pkg::REQ_CLEAR: begin
            fn_count = 0;
            frm_depth = 0;
            loc_count = 0;
            samples_total = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver: offer queued events, hold payload while stalled
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(profile_event('{req_type, req_function_id,
               req_line_number, req_timestamp_ns, req_read_index}));
         end
         if (!req_valid || !req_stall) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               event_item_type ev;
               ev = pending_events.pop_front();
               req_valid <= 1'b1;
               req_type <= ev.kind;
               req_function_id <= ev.func;
               req_line_number <= ev.line;
               req_timestamp_ns <= ev.stamp;
               req_read_index <= ev.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer");
            failed = 1;
         end else begin
            profile_result_type x;
            x = expected_results.pop_front();
            if (rsp_status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_status); failed = 1; end
            if (rsp_entry_slot !== x.entry_slot) begin
               $error("entry_slot exp %0d got %0d", x.entry_slot, rsp_entry_slot);
               failed = 1; end
            if (rsp_sample_slot !== x.sample_slot) begin
               $error("sample_slot exp %0d got %0d", x.sample_slot, rsp_sample_slot);
               failed = 1; end
            if (rsp_calls_seen !== x.calls) begin
               $error("calls_seen exp %0h got %0h", x.calls, rsp_calls_seen); failed = 1; end
            if (rsp_returns_seen !== x.returns) begin
               $error("returns_seen exp %0h got %0h", x.returns, rsp_returns_seen);
               failed = 1; end
            if (rsp_total_time !== x.total) begin
               $error("total_time exp %0h got %0h", x.total, rsp_total_time); failed = 1; end
            if (rsp_own_time !== x.own) begin
               $error("own_time exp %0h got %0h", x.own, rsp_own_time); failed = 1; end
            if (rsp_hits_at_location !== x.hits) begin
               $error("hits_at_location exp %0h got %0h", x.hits, rsp_hits_at_location);
               failed = 1; end
            if (rsp_all_samples !== x.all_samples) begin
               $error("all_samples exp %0h got %0h", x.all_samples, rsp_all_samples);
               failed = 1; end
            if (rsp_slot_function !== x.slot_func) begin
               $error("slot_function exp %0h got %0h", x.slot_func, rsp_slot_function);
               failed = 1; end
            if (rsp_slot_line !== x.slot_line) begin
               $error("slot_line exp %0h got %0h", x.slot_line, rsp_slot_line);
               failed = 1; end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_event(logic [2:0] k, logic [31:0] f, logic [23:0] l,
                            logic [63:0] t, logic [7:0] i);
      pending_events.push_back('{k, f, l, t, i});
   endtask

   // wait until every queued event is taken and every result has arrived
   task automatic drain();
      while (pending_events.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_sampling(logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      sampling_on = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random phase: mostly nested call/return sequences over a small set of functions
   task automatic random_phase(int n, logic [31:0] fbase);
      logic [63:0] clk_ns;
      logic [31:0] open_fns[$];
      int pick;
      logic [31:0] f;
      clk_ns = {$urandom, $urandom} >> $urandom_range(40, 63);
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         clk_ns += $urandom_range(0, 3) == 0 ? 64'd0 : $urandom_range(1, 500);
         if ($urandom_range(49) == 0) clk_ns -= $urandom_range(1, 100);
         f = ($urandom_range(9) == 0) ? $urandom : fbase + $urandom_range(0, 11);
         if (pick < 38) begin
            open_fns.push_back(f);
            add_event(crtp_pkg::REQ_CALL, f, 24'($urandom), clk_ns, 8'($urandom));
         end else if (pick < 65) begin
            if (open_fns.size() > 0 && $urandom_range(9) != 0)
               f = open_fns[$urandom_range(0, open_fns.size() - 1)];
            if (open_fns.size() > 0) void'(open_fns.pop_back());
            add_event(crtp_pkg::REQ_RETURN, f, 24'($urandom), clk_ns, 8'($urandom));
         end else if (pick < 82) begin
            add_event(crtp_pkg::REQ_SAMPLE, f,
                      24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7)),
                      clk_ns, 8'($urandom));
         end else if (pick < 90) begin
            add_event(crtp_pkg::REQ_RD_ENTRY, $urandom, 24'($urandom), {$urandom, $urandom},
                      8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15)));
         end else if (pick < 98) begin
            add_event(crtp_pkg::REQ_RD_SMP, $urandom, 24'($urandom), {$urandom, $urandom},
                      8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)));
         end else if (pick < 99) begin
            add_event(crtp_pkg::REQ_CLEAR, $urandom, 24'($urandom), {$urandom, $urandom},
                      8'($urandom));
            open_fns.delete();
         end else begin
            add_event(3'($urandom_range(6, 7)), $urandom, 24'($urandom),
                      {$urandom, $urandom}, 8'($urandom));
         end
      end
   endtask

   initial begin
      sampling_on = 0;
      fn_count = 0;
      frm_depth = 0;
      loc_count = 0;
      samples_total = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every request, the special cases
      add_event(crtp_pkg::REQ_SAMPLE, 32'h1, 24'h5, 64'd0, 8'd0);            // sampling off
      add_event(crtp_pkg::REQ_RETURN, 32'hFFFF_FFFF, 24'hFF_FFFF, 64'd5, 8'hFF); // empty stack
      add_event(crtp_pkg::REQ_CALL, 32'h0, 24'h0, 64'd100, 8'd0);
      add_event(crtp_pkg::REQ_CALL, 32'hFFFF_FFFF, 24'hFF_FFFF, 64'd200, 8'hFF);
      add_event(crtp_pkg::REQ_RETURN, 32'hFFFF_FFFF, 24'h0, 64'd150, 8'd0);  // clock went back
      add_event(crtp_pkg::REQ_RETURN, 32'h0, 24'h0, 64'd120, 8'd0);  // returns the outer frame
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'd1);
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'd2);           // beyond used
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'hFF);
      add_event(crtp_pkg::REQ_CALL, 32'h7, 24'h0, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h7, 24'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
      add_event(crtp_pkg::REQ_CALL, 32'h8, 24'h0, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h8, 24'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
      add_event(crtp_pkg::REQ_CALL, 32'h9, 24'h0, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h9, 24'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0); // largest elapsed time
      add_event(crtp_pkg::REQ_RD_SMP, 32'h0, 24'h0, 64'd0, 8'd0);
      add_event(3'd6, 32'h1, 24'h1, 64'd1, 8'd1);
      add_event(3'd7, 32'hFFFF_FFFF, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      add_event(crtp_pkg::REQ_CLEAR, 32'h0, 24'h0, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'd0);
      drain();

      write_sampling(1'b1);
      add_event(crtp_pkg::REQ_SAMPLE, 32'h0, 24'h0, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 24'hFF_FFFF, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_SAMPLE, 32'h0, 24'h0, 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_RD_SMP, 32'h0, 24'h0, 64'd0, 8'd1);
      add_event(crtp_pkg::REQ_RD_SMP, 32'h0, 24'h0, 64'd0, 8'd2);
      drain();

      // fill the function table and overflow it, then the frame stack
      for (int i = 0; i < 66; i++)
         add_event(crtp_pkg::REQ_CALL, 32'h100 + i, 24'h0, 64'd1000 + i, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h5000, 24'h0, 64'd2000, 8'd0);
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'd63);
      add_event(crtp_pkg::REQ_RD_ENTRY, 32'h0, 24'h0, 64'd0, 8'd64);
      add_event(crtp_pkg::REQ_CLEAR, 32'h0, 24'h0, 64'd0, 8'd0);
      for (int i = 0; i < 66; i++)
         add_event(crtp_pkg::REQ_CALL, 32'h40 + (i % 3), 24'h0, 64'd10 * i, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h40, 24'h0, 64'd5000, 8'd0);
      add_event(crtp_pkg::REQ_RETURN, 32'h41, 24'h0, 64'd6000, 8'd0);
      // fill the histogram and overflow it
      for (int i = 0; i < 258; i++)
         add_event(crtp_pkg::REQ_SAMPLE, 32'h3, 24'(i), 64'd0, 8'd0);
      add_event(crtp_pkg::REQ_RD_SMP, 32'h0, 24'h0, 64'd0, 8'd255);
      add_event(crtp_pkg::REQ_CLEAR, 32'h0, 24'h0, 64'd0, 8'd0);
      drain();

      // long receiver hold-off while the sender keeps offering
      random_phase(40, 32'h200);
      hold_cycles = 600;
      drain();

      // random phases with varied idling and both settings of the register
      send_idle_pct = 0;  stall_pct = 0;
      random_phase(220, 32'h300);
      drain();
      write_sampling(1'b0);
      send_idle_pct = 71; stall_pct = 0;
      random_phase(220, 32'h400);
      drain();
      write_sampling(1'b1);
      send_idle_pct = 0;  stall_pct = 71;
      random_phase(220, 32'h500);
      drain();
      send_idle_pct = 28; stall_pct = 28;
      random_phase(230, 32'h600);
      drain();

      if (!failed) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== call_return_time_profiler.f =====
+incdir+rtl/core
rtl/core/crtp_pkg.sv
rtl/core/call_return_time_profiler.sv
tb/call_return_time_profiler_tb.sv
